// ===== rtl/core/led_splash_compensated_dimmer_defines.svh =====
// ----------------------------------------------------------------------------
// led splash dimmer assertion macros
// shared property shorthands, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LED_SPLASH_COMPENSATED_DIMMER_DEFINES_SVH
`define LED_SPLASH_COMPENSATED_DIMMER_DEFINES_SVH

// same-cycle implication
`define LSD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg
// shared types, codes and helpers of the led splash dimmer
// ----------------------------------------------------------------------------
package lsd_pkg;

	// item field widths
	localparam int OPCODE_W    = 2;
	localparam int TIME_W      = 32;
	localparam int LEVEL_W     = 8;
	localparam int RINT_W      = 19;
	localparam int LED_IDX_W   = 3;
	localparam int LED_COUNT_W = 4;
	localparam int SPEED_W     = 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_LAMP_ON   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 2'd3;

	localparam logic [LEVEL_W-1:0]     MAX_LEVEL_RST = 8'd255;
	localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 4'd8;
	localparam logic [SPEED_W-1:0]     SPEED_RST     = 8'd128;

	// largest count the led_count register can express
	localparam int LED_COUNT_LIMIT = (2 ** LED_COUNT_W) - 1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK    = 2'd0,
		OP_RESTART = 2'd1,
		OP_LEVEL   = 2'd2,
		OP_OFF     = 2'd3
	} opcode_t;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_RETRY = 1'b1;

	// speed multiplier held with an offset of forty (0..80)
	localparam int M40_W = 7;
	localparam logic [M40_W-1:0] M40_ZERO = 7'd40;
	localparam logic [M40_W-1:0] M40_OFS  = 7'd30;  // m + 10 = m40 - 30
	localparam int IVL_DIV = 10;

	// shared serial divider
	localparam int DIV_W = 25;  // 19 bit interval times 40
	localparam int DVS_W = 6;   // divisor up to 50

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	// floor(speed * 80 / 255) through the reciprocal ((x + 1) * 257) >> 16
	function automatic logic [M40_W-1:0] speed_to_m40(input logic [SPEED_W-1:0] s);
		logic [14:0] x;
		logic [23:0] p;
		x = 15'(s) * 15'd80;
		p = (24'(x) + 24'd1) * 24'd257;
		return p[22:16];
	endfunction

endpackage

// ===== rtl/core/lsd_if.sv =====
// ----------------------------------------------------------------------------
// lsd_if
// valid/ready channels of the led splash dimmer
// ----------------------------------------------------------------------------
interface lsd_cmd_if import lsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [TIME_W-1:0]   now_us;
	logic [LEVEL_W-1:0]  rand_level;
	logic [RINT_W-1:0]   rand_interval;

	modport source (output valid, opcode, now_us, rand_level, rand_interval, input ready);
	modport sink (input valid, opcode, now_us, rand_level, rand_interval, output ready);
endinterface

interface lsd_res_if import lsd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [LED_IDX_W-1:0] led_index;
	logic [LEVEL_W-1:0]   level;
	logic                 last;

	modport source (output valid, kind, led_index, level, last, input ready);
	modport sink (input valid, kind, led_index, level, last, output ready);
endinterface

interface lsd_cfg_if import lsd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/led_splash_compensated_dimmer.sv =====
// ----------------------------------------------------------------------------
// led_splash_compensated_dimmer
// random splash led dimmer with total-brightness compensation
// ----------------------------------------------------------------------------
// One command item is taken at a time and its result items are streamed out
// through a one-deep output register, so a waiting result does not stop the
// sequencer from loading the next one as soon as it is taken. The led levels
// live in a single-port-write, registered-read memory; valid bits cleared by
// reset make every level read as zero until written, so there is no clearing
// pass. Restart only sets the deadline; level changed (lamp on) and switched off
// write every led in use (one memory write per cycle while the result slot is
// free); a tick that fires does a read-back pass over the levels, a run of the
// bit-serial divider for the compensation delta and a read-modify-write of
// every other led (all three skipped for a single led), then a divider run for
// the scaled interval unless the speed is neutral. Stalls on the result channel
// lengthen the passes that emit items. Refused and ignored ticks run no pass.
// ----------------------------------------------------------------------------
`include "led_splash_compensated_dimmer_defines.svh"

module led_splash_compensated_dimmer import lsd_pkg::*; #(
	parameter int MAX_LEDS  = 8,
	parameter int SETTLE_US = 500000
) (
	input logic       clk,
	input logic       arst_n,
	lsd_cfg_if.sink   cfg,
	lsd_cmd_if.sink   cmd,
	lsd_res_if.source res
);

	// leds reachable through led_count
	localparam int NMAX  = (MAX_LEDS < LED_COUNT_LIMIT) ? MAX_LEDS : LED_COUNT_LIMIT;
	localparam int N_W   = $clog2(NMAX + 1);
	localparam int AW    = $clog2(MAX_LEDS);
	localparam int SUM_W = $clog2(NMAX * 255 + 1);
	localparam logic [TIME_W-1:0] SETTLE_T = TIME_W'(SETTLE_US);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FILL,
		ST_CHECK,
		ST_SUM,
		ST_DELTA,
		ST_DELTA_WAIT,
		ST_ADJ_RD,
		ST_ADJ_WR,
		ST_IVL,
		ST_IVL_WAIT
	} state_t;

	typedef struct packed {
		logic                 valid;
		logic                 kind;
		logic [LED_IDX_W-1:0] idx;
		logic [LEVEL_W-1:0]   level;
		logic                 last;
	} emit_t;

	// configuration registers
	logic                   lamp_on_q;
	logic [LEVEL_W-1:0]     max_level_q;
	logic [LED_COUNT_W-1:0] led_count_q;
	logic [SPEED_W-1:0]     speed_q;

	// sequencer state
	state_t             state_q;
	opcode_t            op_q;
	logic [TIME_W-1:0]  now_q;
	logic [LEVEL_W-1:0] rlev_q;
	logic [RINT_W-1:0]  rint_q;
	logic [TIME_W-1:0]  deadline_q;
	logic [N_W-1:0]     next_led_q;
	logic [N_W-1:0]     cur_q;
	logic [N_W-1:0]     idx_q;
	logic [LEVEL_W-1:0] fill_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   ideal_q;
	logic               pend_s1;
	logic signed [SUM_W:0] delta_q;
	logic [M40_W-1:0]   m40_q;

	// result register
	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [LED_IDX_W-1:0] out_idx_q;
	logic [LEVEL_W-1:0]   out_level_q;
	logic                 out_last_q;

	// memory and divider hookup
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [LEVEL_W-1:0] ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [LEVEL_W-1:0] ram_rdata;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// combinational helpers
	logic [N_W-1:0]           n_c;
	logic [N_W-1:0]           cur_c;
	logic [TIME_W-1:0]        elapsed;
	logic                     tick_go;
	logic                     refuse;
	logic                     slot_free;
	logic [N_W:0]             nxt_w;
	logic [N_W:0]             nxt2_w;
	logic                     fill_last;
	logic                     adj_last;
	logic [LEVEL_W+N_W-1:0]   ideal_full;
	logic signed [SUM_W:0]    diff_c;
	logic [SUM_W:0]           diff_mag;
	logic signed [SUM_W+1:0]  v_sum;
	logic [LEVEL_W-1:0]       v_clamp;
	logic [SUM_W:0]           q_small;
	logic                     ivl_slow;
	logic [DIV_W-1:0]         rint_w;
	logic [DIV_W-1:0]         ivl_fac;
	emit_t                    emit;

	lsd_level_ram #(
		.DEPTH (MAX_LEDS),
		.AW    (AW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata  (ram_rdata)
	);

	lsd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration writes, always accepted
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_on_q   <= 1'b0;
			max_level_q <= MAX_LEVEL_RST;
			led_count_q <= LED_COUNT_RST;
			speed_q     <= SPEED_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LAMP_ON:   lamp_on_q   <= cfg.data[0];
				REG_MAX_LEVEL: max_level_q <= cfg.data;
				REG_LED_COUNT: led_count_q <= cfg.data[LED_COUNT_W-1:0];
				REG_SPEED:     speed_q     <= cfg.data;
				default:       ;
			endcase
		end
	end

	// leds in use, clamped to one..NMAX
	always_comb begin
		if (led_count_q == '0) begin
			n_c = N_W'(1);
		end else if (int'(led_count_q) > NMAX) begin
			n_c = N_W'(NMAX);
		end else begin
			n_c = N_W'(led_count_q);
		end
	end

	// deadline reached unless now lies under half the time range before it; also needs lamp on and max level nonzero
	assign elapsed = now_q - deadline_q;
	assign tick_go = lamp_on_q && (max_level_q != '0)
		&& !(elapsed[TIME_W-1] && (elapsed[TIME_W-2:0] != '0));

	// round-robin index with wrap
	assign cur_c = (next_led_q >= n_c) ? '0 : next_led_q;

	// draw refused when out of range or no change
	assign refuse = (rlev_q >= max_level_q) || (rlev_q == ram_rdata);

	assign slot_free = !out_valid_q || res.ready;

	// end-of-stream detection for the fill and compensation walks
	assign nxt_w     = {1'b0, idx_q} + 1'b1;
	assign nxt2_w    = nxt_w + 1'b1;
	assign fill_last = nxt_w >= {1'b0, n_c};
	assign adj_last  = (nxt_w >= {1'b0, n_c})
		|| ((nxt_w == {1'b0, cur_q}) && (nxt2_w >= {1'b0, n_c}));

	// compensation arithmetic
	assign ideal_full = max_level_q * (n_c - N_W'(1));
	assign diff_c     = $signed({1'b0, ideal_q}) - $signed({1'b0, sum_q});
	assign diff_mag   = diff_c[SUM_W] ? (SUM_W + 1)'(-diff_c) : (SUM_W + 1)'(diff_c);
	assign q_small    = (SUM_W + 1)'(div_rsp.quotient);
	assign v_sum      = $signed((SUM_W + 2)'(ram_rdata)) + (SUM_W + 2)'(delta_q);

	always_comb begin
		if (v_sum < 0) begin
			v_clamp = '0;
		end else if (v_sum > $signed((SUM_W + 2)'(max_level_q))) begin
			v_clamp = max_level_q;
		end else begin
			v_clamp = v_sum[LEVEL_W-1:0];
		end
	end

	// interval: slow side is r + r*(-m)/10, fast side r*10/(m+10)
	assign ivl_slow = m40_q < M40_ZERO;
	assign rint_w   = DIV_W'(rint_q);
	assign ivl_fac  = ivl_slow ? DIV_W'(M40_ZERO - m40_q) : DIV_W'(IVL_DIV);

	// memory, divider and result requests of the current step
	always_comb begin
		emit      = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		div_req   = '0;
		case (state_q)
			ST_DECODE: begin
				if (op_q == OP_TICK && tick_go) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(cur_c);
				end
			end
			ST_FILL: begin
				if (slot_free) begin
					ram_we     = 1'b1;
					ram_waddr  = AW'(idx_q);
					ram_wdata  = fill_q;
					emit.valid = 1'b1;
					emit.kind  = KIND_WRITE;
					emit.idx   = LED_IDX_W'(idx_q);
					emit.level = fill_q;
					emit.last  = fill_last;
				end
			end
			ST_CHECK: begin
				if (slot_free) begin
					emit.valid = 1'b1;
					if (refuse) begin
						emit.kind = KIND_RETRY;
						emit.last = 1'b1;
					end else begin
						ram_we     = 1'b1;
						ram_waddr  = AW'(cur_q);
						ram_wdata  = rlev_q;
						emit.kind  = KIND_WRITE;
						emit.idx   = LED_IDX_W'(cur_q);
						emit.level = rlev_q;
						emit.last  = n_c == N_W'(1);
					end
				end
			end
			ST_SUM: begin
				if (idx_q < n_c) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(idx_q);
				end
			end
			ST_DELTA: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(diff_mag);
				div_req.divisor  = DVS_W'(n_c - N_W'(1));
			end
			ST_ADJ_RD: begin
				if (idx_q != cur_q) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(idx_q);
				end
			end
			ST_ADJ_WR: begin
				if (slot_free) begin
					ram_we     = 1'b1;
					ram_waddr  = AW'(idx_q);
					ram_wdata  = v_clamp;
					emit.valid = 1'b1;
					emit.kind  = KIND_WRITE;
					emit.idx   = LED_IDX_W'(idx_q);
					emit.level = v_clamp;
					emit.last  = adj_last;
				end
			end
			ST_IVL: begin
				if (m40_q != M40_ZERO) begin
					div_req.start    = 1'b1;
					div_req.dividend = rint_w * ivl_fac;
					div_req.divisor  = ivl_slow ? DVS_W'(IVL_DIV) : DVS_W'(m40_q - M40_OFS);
				end
			end
			default: ;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_TICK;
			now_q       <= '0;
			rlev_q      <= '0;
			rint_q      <= '0;
			deadline_q  <= '0;
			next_led_q  <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			ideal_q     <= '0;
			pend_s1     <= 1'b0;
			delta_q     <= '0;
			m40_q       <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_WRITE;
			out_idx_q   <= '0;
			out_level_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// result register load or drain
			if (emit.valid) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= emit.kind;
				out_idx_q   <= emit.idx;
				out_level_q <= emit.level;
				out_last_q  <= emit.last;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						op_q    <= opcode_t'(cmd.opcode);
						now_q   <= cmd.now_us;
						rlev_q  <= cmd.rand_level;
						rint_q  <= cmd.rand_interval;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					idx_q   <= '0;
					ideal_q <= SUM_W'(ideal_full);
					m40_q   <= speed_to_m40(speed_q);
					case (op_q)
						OP_RESTART: begin
							deadline_q <= now_q;
							state_q    <= ST_IDLE;
						end
						OP_LEVEL: begin
							if (lamp_on_q) begin
								fill_q     <= max_level_q;
								deadline_q <= now_q + SETTLE_T;
								state_q    <= ST_FILL;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						OP_OFF: begin
							fill_q  <= '0;
							state_q <= ST_FILL;
						end
						default: begin
							if (tick_go) begin
								next_led_q <= cur_c;
								cur_q      <= cur_c;
								state_q    <= ST_CHECK;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					endcase
				end
				ST_FILL: begin
					if (slot_free) begin
						if (fill_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= N_W'(nxt_w);
						end
					end
				end
				ST_CHECK: begin
					if (slot_free) begin
						if (refuse) begin
							state_q <= ST_IDLE;
						end else begin
							next_led_q <= cur_q + 1'b1;
							sum_q      <= '0;
							pend_s1    <= 1'b0;
							idx_q      <= '0;
							state_q    <= (n_c == N_W'(1)) ? ST_IVL : ST_SUM;
						end
					end
				end
				ST_SUM: begin
					// read stream one ahead of the adder
					pend_s1 <= idx_q < n_c;
					if (idx_q < n_c) begin
						idx_q <= idx_q + 1'b1;
					end
					if (pend_s1) begin
						sum_q <= sum_q + SUM_W'(ram_rdata);
					end
					if (idx_q == n_c && !pend_s1) begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					delta_q <= diff_c;
					state_q <= ST_DELTA_WAIT;
				end
				ST_DELTA_WAIT: begin
					if (div_rsp.done) begin
						// truncation toward zero: divide the magnitude, restore sign
						delta_q <= delta_q[SUM_W] ? -$signed(q_small) : $signed(q_small);
						idx_q   <= '0;
						state_q <= ST_ADJ_RD;
					end
				end
				ST_ADJ_RD: begin
					if (idx_q == cur_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_ADJ_WR;
					end
				end
				ST_ADJ_WR: begin
					if (slot_free) begin
						if (adj_last) begin
							state_q <= ST_IVL;
						end else begin
							idx_q   <= N_W'(nxt_w);
							state_q <= ST_ADJ_RD;
						end
					end
				end
				ST_IVL: begin
					if (m40_q == M40_ZERO) begin
						deadline_q <= now_q + TIME_W'(rint_q);
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_IVL_WAIT;
					end
				end
				ST_IVL_WAIT: begin
					if (div_rsp.done) begin
						if (ivl_slow) begin
							deadline_q <= now_q + TIME_W'(rint_q) + TIME_W'(div_rsp.quotient);
						end else begin
							deadline_q <= now_q + TIME_W'(div_rsp.quotient);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd.ready     = state_q == ST_IDLE;
	assign res.valid     = out_valid_q;
	assign res.kind      = out_kind_q;
	assign res.led_index = out_idx_q;
	assign res.level     = out_level_q;
	assign res.last      = out_last_q;

	// checks
	`LSD_ASSERT_IMP(a_ram_no_collide, ram_we && ram_re, ram_waddr != ram_raddr, "level ram read and write hit the same entry")
	`LSD_ASSERT_IMP(a_retry_is_last, res.valid && res.kind == KIND_RETRY, res.last && res.level == '0 && res.led_index == '0, "retry item is not a lone final item")
	`LSD_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`LSD_ASSERT_NXT(a_emit_loads_out, emit.valid, res.valid, "emitted item missing from the result register")
	`LSD_ASSERT_IMP(a_next_led_range, state_q == ST_IDLE, next_led_q <= N_W'(NMAX), "next led index beyond the channel range")

endmodule

// ===== rtl/core/lsd_level_ram.sv =====
// ----------------------------------------------------------------------------
// lsd_level_ram
// per-led level store, one write and one registered read port
// ----------------------------------------------------------------------------
module lsd_level_ram import lsd_pkg::*; #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [LEVEL_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [LEVEL_W-1:0] rdata
);

	logic [LEVEL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [LEVEL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rdata_q <= '0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rdata_q <= vld_q[raddr] ? mem[raddr] : '0;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/lsd_divider.sv =====
// ----------------------------------------------------------------------------
// lsd_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsd_divider import lsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;

	logic [DVS_W:0] trial;
	logic           ge;

	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W - 1);
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
				quo_q <= {quo_q[DIV_W-2:0], ge};
				rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
